@@ src/mrd_pkg.sv @@
// Shared constants, types and the CRC-16/MODBUS byte update for the response deframer.
`timescale 1ns / 1ps

package mrd_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 50;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned PLEN_W    = 6;
  localparam int unsigned GSIZE_W   = 3;
  localparam int unsigned FILL_W    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned HDR_BYTES = 3;

  localparam logic [CRC_W-1:0]   CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]   CRC_POLY = 16'hA001;
  localparam logic [PLEN_W-1:0]  PLEN_RST = 6'd4;
  localparam logic [GSIZE_W-1:0] GSIZE_RST = 3'd4;
  localparam logic [GSIZE_W-1:0] GSIZE_MAX = 3'd4;

  typedef enum logic [0:0] {
    REG_PAYLOAD_BYTES = 1'b0,
    REG_GROUP_BYTES   = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    KIND_VALUE = 1'b0,
    KIND_END   = 1'b1
  } kind_t;

  typedef struct packed {
    logic [PLEN_W-1:0]  payload_bytes;
    logic [GSIZE_W-1:0] group_bytes;
  } cfg_t;

  typedef struct packed {
    logic               vld;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               crc_ok;
    logic               last;
  } res_t;

  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] x;
    x = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

@@ src/mrd_cfg.sv @@
// APB-style configuration registers: payload length and group size.
`timescale 1ns / 1ps

module mrd_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mrd_pkg::APB_AW-1:0] paddr,
  input  logic [mrd_pkg::APB_DW-1:0] pwdata,
  output logic [mrd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output mrd_pkg::cfg_t              cfg
);

  mrd_pkg::cfg_t     cfg_r;
  mrd_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = mrd_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.payload_bytes <= mrd_pkg::PLEN_RST;
      cfg_r.group_bytes   <= mrd_pkg::GSIZE_RST;
    end else if (wr_en) begin
      unique case (idx)
        mrd_pkg::REG_PAYLOAD_BYTES: cfg_r.payload_bytes <= pwdata[mrd_pkg::PLEN_W-1:0];
        mrd_pkg::REG_GROUP_BYTES:   cfg_r.group_bytes   <= pwdata[mrd_pkg::GSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      mrd_pkg::REG_PAYLOAD_BYTES: prdata[mrd_pkg::PLEN_W-1:0]  = cfg_r.payload_bytes;
      mrd_pkg::REG_GROUP_BYTES:   prdata[mrd_pkg::GSIZE_W-1:0] = cfg_r.group_bytes;
      default: ;
    endcase
  end

endmodule

@@ src/mrd_frame.sv @@
// Frame tracker: byte position, running CRC, group assembly and result decode.
`timescale 1ns / 1ps

module mrd_frame #(
  parameter int unsigned MAX_FRAME_BYTES = mrd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [mrd_pkg::BYTE_W-1:0] rx_byte,
  input  mrd_pkg::cfg_t              cfg,
  output mrd_pkg::res_t              res
);

  localparam int unsigned PosW     = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned CmpW     = (PosW > 7) ? PosW : 7;
  localparam int unsigned PlenCapI = ((MAX_FRAME_BYTES - 5) > ((1 << mrd_pkg::PLEN_W) - 1))
                                     ? ((1 << mrd_pkg::PLEN_W) - 1) : (MAX_FRAME_BYTES - 5);
  localparam logic [mrd_pkg::PLEN_W-1:0] PlenCap = mrd_pkg::PLEN_W'(PlenCapI);
  localparam logic [CmpW-1:0] PosMax = CmpW'(PlenCapI + mrd_pkg::HDR_BYTES + 1);

  logic [PosW-1:0]                pos_r, pos_nxt;
  logic [mrd_pkg::CRC_W-1:0]      crc_r, crc_nxt;
  logic [mrd_pkg::VALUE_W-1:0]    grp_r, grp_nxt;
  logic [mrd_pkg::FILL_W-1:0]     fill_r, fill_nxt;
  logic [mrd_pkg::BYTE_W-1:0]     crc_lo_r, crc_lo_nxt;

  logic [mrd_pkg::PLEN_W-1:0]     plen;
  logic [mrd_pkg::GSIZE_W-1:0]    gsize;
  logic [CmpW-1:0]                crc_lo_pos;
  logic [CmpW-1:0]                pos_ext;
  logic [mrd_pkg::FILL_W-1:0]     fill_inc;
  logic [mrd_pkg::VALUE_W-1:0]    grp_inc;
  logic [mrd_pkg::CRC_W-1:0]      crc_upd;

  assign plen       = (cfg.payload_bytes > PlenCap) ? PlenCap : cfg.payload_bytes;
  assign gsize      = ((cfg.group_bytes == '0) || (cfg.group_bytes > mrd_pkg::GSIZE_MAX))
                      ? mrd_pkg::GSIZE_MAX : cfg.group_bytes;
  assign crc_lo_pos = CmpW'(mrd_pkg::HDR_BYTES) + CmpW'(plen);
  assign pos_ext    = CmpW'(pos_r);
  assign fill_inc   = fill_r + 1'b1;
  assign grp_inc    = {grp_r[mrd_pkg::VALUE_W-mrd_pkg::BYTE_W-1:0], rx_byte};
  assign crc_upd    = mrd_pkg::crc_update(crc_r, rx_byte);

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    grp_nxt    = grp_r;
    fill_nxt   = fill_r;
    crc_lo_nxt = crc_lo_r;
    res        = '0;
    if (pos_ext < CmpW'(mrd_pkg::HDR_BYTES)) begin
      crc_nxt = crc_upd;
      pos_nxt = pos_r + 1'b1;
    end else if (pos_ext < crc_lo_pos) begin
      crc_nxt = crc_upd;
      pos_nxt = pos_r + 1'b1;
      if (fill_inc >= gsize) begin
        res.vld   = 1'b1;
        res.kind  = mrd_pkg::KIND_VALUE;
        res.value = grp_inc;
        grp_nxt   = '0;
        fill_nxt  = '0;
      end else begin
        grp_nxt  = grp_inc;
        fill_nxt = fill_inc;
      end
    end else if (pos_ext == crc_lo_pos) begin
      crc_lo_nxt = rx_byte;
      pos_nxt    = pos_r + 1'b1;
    end else begin
      res.vld    = 1'b1;
      res.kind   = mrd_pkg::KIND_END;
      res.crc_ok = ({rx_byte, crc_lo_r} == crc_r);
      res.last   = 1'b1;
      pos_nxt    = '0;
      crc_nxt    = mrd_pkg::CRC_INIT;
      grp_nxt    = '0;
      fill_nxt   = '0;
      crc_lo_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= mrd_pkg::CRC_INIT;
      grp_r    <= '0;
      fill_r   <= '0;
      crc_lo_r <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      grp_r    <= grp_nxt;
      fill_r   <= fill_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < mrd_pkg::FILL_W'(mrd_pkg::GSIZE_MAX))
    else $error("group fill reached a full group without transfer");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CmpW'(pos_r) <= PosMax)
    else $error("byte position beyond frame end");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.vld && res.last |=> (pos_r == '0) && (crc_r == mrd_pkg::CRC_INIT)
                                    && (fill_r == '0))
    else $error("frame state not cleared after frame end");

  a_group_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.vld && !res.last |=> (fill_r == '0) && (grp_r == '0))
    else $error("group not cleared after value transfer");

endmodule

@@ src/modbus_rtu_response_deframer_top.sv @@
// Top level: input register, frame tracker, result register and configuration port.
// Order: each byte is held in the input register, its result in the result register.
// Throughput: one byte per cycle; the input register advances whenever the result
// register is free or draining, so a stalled result blocks only a byte that yields one.
// Reset: synchronous active-low rst_n clears the frame state (CRC to 0xFFFF) and both
// valid flags, and sets payload_bytes and group_bytes to 4; no clearing pass.
`timescale 1ns / 1ps

module modbus_rtu_response_deframer_top #(
  parameter int unsigned MAX_FRAME_BYTES = mrd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mrd_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [mrd_pkg::VALUE_W-1:0] out_value,
  output logic                        out_crc_ok,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrd_pkg::APB_AW-1:0]  paddr,
  input  logic [mrd_pkg::APB_DW-1:0]  pwdata,
  output logic [mrd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  mrd_pkg::cfg_t              cfg;
  mrd_pkg::res_t              res;
  mrd_pkg::res_t              out_r;
  logic                       s1_vld_r;
  logic [mrd_pkg::BYTE_W-1:0] s1_byte_r;
  logic                       s1_adv;

  mrd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrd_frame #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign s1_adv   = s1_vld_r && (!res.vld || !out_r.vld || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else if (s1_adv && res.vld) begin
      out_r.vld <= 1'b1;
    end else if (out_ready) begin
      out_r.vld <= 1'b0;
    end
    if (s1_adv && res.vld) begin
      out_r.kind   <= res.kind;
      out_r.value  <= res.value;
      out_r.crc_ok <= res.crc_ok;
      out_r.last   <= res.last;
    end
  end

  assign out_valid  = out_r.vld;
  assign out_kind   = logic'(out_r.kind);
  assign out_value  = out_r.value;
  assign out_crc_ok = out_r.crc_ok;
  assign out_last   = out_r.last;

endmodule
